// ===== src/dmce_pkg.sv =====
// Package: types, command codes and constants shared by the display command encoder.
`timescale 1ns / 1ps

package dmce_pkg;

    // Number of bytes a command can expand into
    localparam int unsigned MAX_BYTES = 6;

    // Command byte prefixes sent to the display
    localparam logic [7:0] CMD_DIGIT_SEL = 8'hA0;
    localparam logic [7:0] CMD_CLEAR_ALL = 8'hC0;
    localparam logic [7:0] CMD_BRIGHT    = 8'hF0;
    localparam logic [7:0] CMD_SLEEP     = 8'hFF;
    localparam logic [4:0] ROW_MASK      = 5'h1F;

    // Range limits and reset brightness
    localparam logic [2:0] DIGIT_MAX    = 3'd4;
    localparam logic [2:0] LEVEL_MAX    = 3'd6;
    localparam logic [2:0] BRIGHT_RESET = 3'd6;

    typedef enum logic [2:0] {
        ACT_WRITE_GLYPH = 3'd0,
        ACT_CLEAR_DIGIT = 3'd1,
        ACT_CLEAR_ALL   = 3'd2,
        ACT_SET_BRIGHT  = 3'd3,
        ACT_SLEEP       = 3'd4,
        ACT_WAKE        = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_180 = 2'd1,
        ROT_90  = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    // Input item
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  digit;
        logic [24:0] bitmap;
        logic [1:0]  rotation;
        logic [2:0]  level;
    } t_cmd_in;

    // Result item
    typedef struct packed {
        logic [7:0] command_byte;
        logic       error;
        logic       last;
    } t_cmd_out;

    // Classified command: byte list handed from front to back
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      error;
    } t_desc;

endpackage

// ===== src/dot_matrix_command_encoder.sv =====
// Top level: command encoder for a five-character 5x5 dot-matrix display.
//
//  channel   direction  handshake                     payload
//  command   in         i_cmd_valid / o_cmd_ready     i_cmd  (dmce_pkg::t_cmd_in)
//  byte      out        o_byte_valid / i_byte_ready   o_byte (dmce_pkg::t_cmd_out)
//
// A command is classified in the cycle it is accepted and queued; the back end emits one
// byte per cycle unless the output stalls. A glyph write or digit clear sends 6 bytes,
// clear all 2, and other or out-of-range commands 1. The queue and the output register
// lie between acceptance and the first byte. Two commands can wait in the queue.
// Synchronous active-low reset empties the queue and sets brightness to 6.
// A stalled output holds its byte; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps

module dot_matrix_command_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmce_pkg::t_cmd_in  i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    output dmce_pkg::t_cmd_out o_byte,
    output logic               o_byte_valid,
    input  logic               i_byte_ready
);

    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;
    dmce_pkg::t_desc push_desc;
    dmce_pkg::t_desc head_desc;

    dmce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    dmce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    dmce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_desc     (head_desc),
        .o_q_pop      (q_pop),
        .o_byte       (o_byte),
        .o_byte_valid (o_byte_valid),
        .i_byte_ready (i_byte_ready)
    );

endmodule

// ===== src/dmce_front.sv =====
// Front end: accepts commands, checks ranges, keeps brightness and builds byte lists.
`timescale 1ns / 1ps

module dmce_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dmce_pkg::t_cmd_in i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  logic             i_q_ready,
    output logic             o_push,
    output dmce_pkg::t_desc  o_desc
);

    logic [2:0]      r_bright;
    logic [2:0]      n_bright;
    logic            accept;
    logic            known;
    dmce_pkg::t_desc desc;
    logic [4:0]      pix;
    logic [2:0]      addr;

    assign o_cmd_ready = i_q_ready;
    assign accept      = i_cmd_valid && i_q_ready;

    // Build the byte list for the incoming command
    always_comb begin
        desc  = '0;
        known = 1'b1;
        pix   = '0;
        addr  = '0;
        case (dmce_pkg::t_action'(i_cmd.action))
            dmce_pkg::ACT_WRITE_GLYPH: begin
                if (i_cmd.digit > dmce_pkg::DIGIT_MAX) begin
                    desc.count = 3'd1;
                    desc.error = 1'b1;
                end else begin
                    desc.count    = 3'd6;
                    desc.bytes[0] = dmce_pkg::CMD_DIGIT_SEL | {5'd0, i_cmd.digit};
                    for (int s = 0; s < 5; s++) begin
                        addr = 3'(s);
                        for (int c = 0; c < 5; c++) begin
                            case (dmce_pkg::t_rotation'(i_cmd.rotation))
                                dmce_pkg::ROT_180: pix[c] = i_cmd.bitmap[5*s + 4 - c];
                                dmce_pkg::ROT_90:  pix[c] = i_cmd.bitmap[5*c + 4 - s];
                                dmce_pkg::ROT_270: pix[c] = i_cmd.bitmap[5*(4 - c) + s];
                                default:           pix[c] = i_cmd.bitmap[5*s + c];
                            endcase
                        end
                        if (i_cmd.rotation == dmce_pkg::ROT_180) begin
                            addr = 3'(4 - s);
                        end
                        desc.bytes[s+1] = {addr, pix & dmce_pkg::ROW_MASK};
                    end
                end
            end
            dmce_pkg::ACT_CLEAR_DIGIT: begin
                if (i_cmd.digit > dmce_pkg::DIGIT_MAX) begin
                    desc.count = 3'd1;
                    desc.error = 1'b1;
                end else begin
                    desc.count    = 3'd6;
                    desc.bytes[0] = dmce_pkg::CMD_DIGIT_SEL | {5'd0, i_cmd.digit};
                    for (int s = 0; s < 5; s++) begin
                        desc.bytes[s+1] = {3'(s), 5'd0};
                    end
                end
            end
            dmce_pkg::ACT_CLEAR_ALL: begin
                desc.count    = 3'd2;
                desc.bytes[0] = dmce_pkg::CMD_CLEAR_ALL;
                desc.bytes[1] = dmce_pkg::CMD_BRIGHT | {5'd0, r_bright};
            end
            dmce_pkg::ACT_SET_BRIGHT: begin
                desc.count = 3'd1;
                if (i_cmd.level > dmce_pkg::LEVEL_MAX) begin
                    desc.error = 1'b1;
                end else begin
                    desc.bytes[0] = dmce_pkg::CMD_BRIGHT | {5'd0, i_cmd.level};
                end
            end
            dmce_pkg::ACT_SLEEP: begin
                desc.count    = 3'd1;
                desc.bytes[0] = dmce_pkg::CMD_SLEEP;
            end
            dmce_pkg::ACT_WAKE: begin
                desc.count    = 3'd1;
                desc.bytes[0] = dmce_pkg::CMD_BRIGHT | {5'd0, r_bright};
            end
            default: begin
                // unused action codes are dropped
                known = 1'b0;
            end
        endcase
    end

    assign o_push = accept && known;
    assign o_desc = desc;

    // Update brightness on an in-range set
    always_comb begin
        n_bright = r_bright;
        if (accept && i_cmd.action == dmce_pkg::ACT_SET_BRIGHT
                && i_cmd.level <= dmce_pkg::LEVEL_MAX) begin
            n_bright = i_cmd.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= dmce_pkg::BRIGHT_RESET;
        end else begin
            r_bright <= n_bright;
        end
    end

endmodule

// ===== src/dmce_queue.sv =====
// Two-entry queue of classified commands between front and back.
`timescale 1ns / 1ps

module dmce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dmce_pkg::t_desc i_desc,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output dmce_pkg::t_desc o_desc
);

    dmce_pkg::t_desc r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry data
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy beyond two entries");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with occupancy");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> o_valid)
        else $error("pushed entry not visible");
`endif

endmodule

// ===== src/dmce_back.sv =====
// Back end: steps through each byte list and drives the registered result channel.
`timescale 1ns / 1ps

module dmce_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  dmce_pkg::t_desc    i_q_desc,
    output logic               o_q_pop,
    output dmce_pkg::t_cmd_out o_byte,
    output logic               o_byte_valid,
    input  logic               i_byte_ready
);

    dmce_pkg::t_desc    r_desc;
    logic [2:0]         r_idx;
    logic               r_busy;
    dmce_pkg::t_cmd_out r_out;
    logic               r_ov;

    dmce_pkg::t_desc    n_desc;
    logic [2:0]         n_idx;
    logic               n_busy;
    dmce_pkg::t_cmd_out n_out;
    logic               n_ov;

    dmce_pkg::t_desc    src_desc;
    logic [2:0]         src_idx;
    logic               src_valid;
    logic               src_last;
    logic               out_free;
    logic               load;
    logic [7:0]         cur_byte;

    // Pick the command in progress, or the queue head when idle
    always_comb begin
        src_desc  = r_busy ? r_desc : i_q_desc;
        src_idx   = r_busy ? r_idx : 3'd0;
        src_valid = r_busy || i_q_valid;
        src_last  = (src_idx == src_desc.count - 3'd1);
        out_free  = !r_ov || i_byte_ready;
        load      = out_free && src_valid;
        case (src_idx)
            3'd0:    cur_byte = src_desc.bytes[0];
            3'd1:    cur_byte = src_desc.bytes[1];
            3'd2:    cur_byte = src_desc.bytes[2];
            3'd3:    cur_byte = src_desc.bytes[3];
            3'd4:    cur_byte = src_desc.bytes[4];
            3'd5:    cur_byte = src_desc.bytes[5];
            default: cur_byte = 8'd0;
        endcase
    end

    assign o_q_pop = load && !r_busy;

    // Advance the sequencer and load the output register
    always_comb begin
        n_desc = r_desc;
        n_idx  = r_idx;
        n_busy = r_busy;
        n_out  = r_out;
        n_ov   = r_ov;
        if (load) begin
            n_busy             = !src_last;
            n_idx              = src_idx + 3'd1;
            n_desc             = src_desc;
            n_out.command_byte = cur_byte;
            n_out.error        = src_desc.error;
            n_out.last         = src_last;
            n_ov               = 1'b1;
        end else if (i_byte_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_byte       = r_out;
    assign o_byte_valid = r_ov;

`ifndef SYNTH
    a_busy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 3'd0 && r_idx < r_desc.count))
        else $error("byte index outside the command in progress");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !r_busy)
        else $error("queue popped while a command is in progress");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && src_last) |=> (!r_busy && o_byte.last))
        else $error("final byte did not end the command");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_byte.error) |-> (o_byte.last && o_byte.command_byte == 8'd0))
        else $error("error result is not a single zero byte");
`endif

endmodule
